// ===== design/mscc_pkg.sv =====
// shared constants, types and helpers for the minute/second countdown controller
// no dependencies; imported by mscc_knob_scale and the top level
package mscc_pkg;

   // knob mapping and time limits
   localparam int unsigned KNOB_MAX    = 4095;
   localparam int unsigned MAX_MINUTES = 10;
   localparam int unsigned MAX_SECONDS = 59;

   // field widths
   localparam int unsigned KNOB_W = 12;
   localparam int unsigned MIN_W  = 4;
   localparam int unsigned SEC_W  = 6;
   localparam int unsigned KIND_W = 3;

   // knob product and reciprocal divide by KNOB_MAX
   // product of a 12-bit sample and a limit of at most 59 fits 18 bits;
   // a shift of 18 + 16 makes the reciprocal exact for any divisor below 2^16
   localparam int unsigned PROD_W    = 18;
   localparam int unsigned DIV_SHIFT = 34;
   localparam int unsigned RECIP_W   = 27;
   localparam logic [RECIP_W-1:0] KNOB_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(KNOB_MAX) - 64'd1) / 64'(KNOB_MAX));

   // seconds value after a borrow from the minutes
   localparam logic [SEC_W-1:0] SECONDS_WRAP = 6'd59;

   // input word kinds
   localparam logic [KIND_W-1:0] KIND_TICK = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FIRE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UP   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DOWN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_KNOB = 3'd4;

   // timer modes, one-hot
   typedef enum logic [3:0] {
      MODE_SETTING = 4'b0001,
      MODE_RUNNING = 4'b0010,
      MODE_PAUSED  = 4'b0100,
      MODE_ELAPSED = 4'b1000
   } mode_type;

   // mode codes as seen on the result word
   localparam logic [1:0] CODE_SETTING = 2'd0;
   localparam logic [1:0] CODE_RUNNING = 2'd1;
   localparam logic [1:0] CODE_PAUSED  = 2'd2;
   localparam logic [1:0] CODE_ELAPSED = 2'd3;

   // lamp colours, one per mode
   localparam logic [1:0] LAMP_RED    = 2'd0;
   localparam logic [1:0] LAMP_GREEN  = 2'd1;
   localparam logic [1:0] LAMP_ORANGE = 2'd2;
   localparam logic [1:0] LAMP_BLUE   = 2'd3;

   // knob stage result handed to the scaler
   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic              sat;
   } knob_type;

endpackage

// ===== design/mscc_knob_scale.sv =====
// knob value scaler: floor(product / KNOB_MAX) by reciprocal multiply, saturating
// depends on mscc_pkg
module mscc_knob_scale
   import mscc_pkg::*;
(
   input  knob_type         knob,
   input  logic [SEC_W-1:0] top,
   output logic [SEC_W-1:0] value
);

   localparam int unsigned FULL_W = PROD_W + RECIP_W;

   logic [FULL_W-1:0] full;

   // exact quotient from the high bits of the reciprocal product
   assign full  = FULL_W'(knob.prod) * FULL_W'(KNOB_RECIP);

   // samples at or above full scale map to the limit
   assign value = knob.sat ? top : full[DIV_SHIFT +: SEC_W];

endmodule

// ===== design/minute_second_countdown_controller_top.sv =====
// minute/second countdown controller, top level
// depends on mscc_pkg and mscc_knob_scale
//
// Usage:
//   req channel carries one event word (kind plus two knob samples); rsp channel
//   returns one result word per event: mode, remaining time, chosen time, lamp
//   colour and beep. Both use valid/stall; a word moves on a rising edge with
//   valid high and stall low.
// Timing:
//   a word accepted into the knob stage register has had its knob samples
//   multiplied by the limits; as it moves on into the result/state register,
//   the divide-by-full-scale, the mode update and the time update happen and the result word is shown.
//   There are two registers (knob stage and result/state register); throughput
//   is one word per cycle while the result register is not held by rsp_stall.
// Stall:
//   while rsp_stall holds a result, the knob stage may still take one more
//   word; req_stall rises only when both stages are full. Timer state changes
//   only as a word enters the result register, so results stay in order.
// Reset:
//   synchronous, active high; both stages empty, mode setting, all times zero.
module minute_second_countdown_controller_top
   import mscc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [KNOB_W-1:0] req_minutes_knob,
   input  logic [KNOB_W-1:0] req_seconds_knob,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_mode,
   output logic [MIN_W-1:0]  rsp_minutes_left,
   output logic [SEC_W-1:0]  rsp_seconds_left,
   output logic [MIN_W-1:0]  rsp_minutes_chosen,
   output logic [SEC_W-1:0]  rsp_seconds_chosen,
   output logic [1:0]        rsp_lamp_colour,
   output logic              rsp_beep_on
);

   // knob stage
   logic              a_valid_ff;
   logic [KIND_W-1:0] a_kind_ff;
   knob_type          a_min_ff, a_min_in;
   knob_type          a_sec_ff, a_sec_in;

   // result / timer state
   logic              rsp_valid_ff;
   mode_type          mode_ff, mode_in;
   logic [MIN_W-1:0]  min_left_ff, min_left_in;
   logic [SEC_W-1:0]  sec_left_ff, sec_left_in;
   logic [MIN_W-1:0]  min_set_ff, min_set_in;
   logic [SEC_W-1:0]  sec_set_ff, sec_set_in;

   logic              out_free;
   logic              advance;
   logic              take_req;
   logic [SEC_W-1:0]  min_scaled;
   logic [SEC_W-1:0]  sec_scaled;
   logic [MIN_W-1:0]  tick_min;
   logic [SEC_W-1:0]  tick_sec;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = a_valid_ff && out_free;
   assign req_stall = a_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;

   // knob products and full-scale detection
   assign a_min_in.prod = PROD_W'(req_minutes_knob) * PROD_W'(MAX_MINUTES);
   assign a_min_in.sat  = 17'(req_minutes_knob) >= 17'(KNOB_MAX);
   assign a_sec_in.prod = PROD_W'(req_seconds_knob) * PROD_W'(MAX_SECONDS);
   assign a_sec_in.sat  = 17'(req_seconds_knob) >= 17'(KNOB_MAX);

   // knob stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         a_valid_ff <= req_valid;
      end
      if (take_req) begin
         a_kind_ff <= req_kind;
         a_min_ff  <= a_min_in;
         a_sec_ff  <= a_sec_in;
      end
   end

   // divide by full scale
   mscc_knob_scale u_min_scale (
      .knob  (a_min_ff),
      .top   (SEC_W'(MAX_MINUTES)),
      .value (min_scaled)
   );

   mscc_knob_scale u_sec_scale (
      .knob  (a_sec_ff),
      .top   (SEC_W'(MAX_SECONDS)),
      .value (sec_scaled)
   );

   // one-second decrement with borrow
   always_comb begin
      tick_min = min_left_ff;
      tick_sec = sec_left_ff;
      if (sec_left_ff != '0) begin
         tick_sec = sec_left_ff - SEC_W'(1);
      end else if (min_left_ff != '0) begin
         tick_min = min_left_ff - MIN_W'(1);
         tick_sec = SECONDS_WRAP;
      end
   end

   // mode and time update
   always_comb begin
      mode_in     = mode_ff;
      min_left_in = min_left_ff;
      sec_left_in = sec_left_ff;
      min_set_in  = min_set_ff;
      sec_set_in  = sec_set_ff;
      case (mode_ff)
         MODE_SETTING: begin
            if (a_kind_ff == KIND_KNOB) begin
               min_set_in  = min_scaled[MIN_W-1:0];
               sec_set_in  = sec_scaled;
               min_left_in = min_scaled[MIN_W-1:0];
               sec_left_in = sec_scaled;
            end else if (a_kind_ff == KIND_FIRE) begin
               mode_in = MODE_RUNNING;
            end
         end
         MODE_RUNNING: begin
            if (a_kind_ff == KIND_TICK) begin
               min_left_in = tick_min;
               sec_left_in = tick_sec;
               if (tick_min == '0 && tick_sec == '0) begin
                  mode_in = MODE_ELAPSED;
               end
            end else if (a_kind_ff == KIND_FIRE) begin
               mode_in = MODE_PAUSED;
            end
         end
         MODE_PAUSED: begin
            if (a_kind_ff == KIND_FIRE) begin
               mode_in = MODE_RUNNING;
            end else if (a_kind_ff == KIND_UP) begin
               min_left_in = min_set_ff;
               sec_left_in = sec_set_ff;
               mode_in     = MODE_RUNNING;
            end else if (a_kind_ff == KIND_DOWN) begin
               min_left_in = min_set_ff;
               sec_left_in = sec_set_ff;
               mode_in     = MODE_SETTING;
            end
         end
         MODE_ELAPSED: begin
            if (a_kind_ff == KIND_FIRE) begin
               min_left_in = min_set_ff;
               sec_left_in = sec_set_ff;
               mode_in     = MODE_SETTING;
            end
         end
         default: begin
            mode_in = MODE_SETTING;
         end
      endcase
   end

   // result and timer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_SETTING;
         min_left_ff  <= '0;
         sec_left_ff  <= '0;
         min_set_ff   <= '0;
         sec_set_ff   <= '0;
      end else begin
         rsp_valid_ff <= advance || (rsp_valid_ff && rsp_stall);
         if (advance) begin
            mode_ff     <= mode_in;
            min_left_ff <= min_left_in;
            sec_left_ff <= sec_left_in;
            min_set_ff  <= min_set_in;
            sec_set_ff  <= sec_set_in;
         end
      end
   end

   // result word
   always_comb begin
      case (mode_ff)
         MODE_SETTING: begin
            rsp_mode        = CODE_SETTING;
            rsp_lamp_colour = LAMP_RED;
         end
         MODE_RUNNING: begin
            rsp_mode        = CODE_RUNNING;
            rsp_lamp_colour = LAMP_GREEN;
         end
         MODE_PAUSED: begin
            rsp_mode        = CODE_PAUSED;
            rsp_lamp_colour = LAMP_ORANGE;
         end
         MODE_ELAPSED: begin
            rsp_mode        = CODE_ELAPSED;
            rsp_lamp_colour = LAMP_BLUE;
         end
         default: begin
            rsp_mode        = CODE_SETTING;
            rsp_lamp_colour = LAMP_RED;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_minutes_left   = min_left_ff;
   assign rsp_seconds_left   = sec_left_ff;
   assign rsp_minutes_chosen = min_set_ff;
   assign rsp_seconds_chosen = sec_set_ff;
   assign rsp_beep_on        = (mode_ff == MODE_ELAPSED);

endmodule

// ===== sim/mscc_checker.sv =====
// result checker for the minute/second countdown controller
// predicts one result word per accepted event word and compares them in order
// depends on mscc_pkg
module mscc_checker
   import mscc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [KNOB_W-1:0] req_minutes_knob,
   input  logic [KNOB_W-1:0] req_seconds_knob,

   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [1:0]        rsp_mode,
   input  logic [MIN_W-1:0]  rsp_minutes_left,
   input  logic [SEC_W-1:0]  rsp_seconds_left,
   input  logic [MIN_W-1:0]  rsp_minutes_chosen,
   input  logic [SEC_W-1:0]  rsp_seconds_chosen,
   input  logic [1:0]        rsp_lamp_colour,
   input  logic              rsp_beep_on,

   output int                fail_count,
   output int                words_pending
);

   typedef struct packed {
      logic [1:0]       mode;
      logic [MIN_W-1:0] minutes_left;
      logic [SEC_W-1:0] seconds_left;
      logic [MIN_W-1:0] minutes_chosen;
      logic [SEC_W-1:0] seconds_chosen;
      logic [1:0]       lamp_colour;
      logic             beep_on;
   } timer_word_type;

   timer_word_type timer_words_due[$];

   // predicted timer state
   logic [1:0]       timer_mode;
   logic [MIN_W-1:0] left_min;
   logic [SEC_W-1:0] left_sec;
   logic [MIN_W-1:0] chosen_min;
   logic [SEC_W-1:0] chosen_sec;

   // knob sample to whole units, saturating at full scale
   function automatic int unsigned knob_to_units(input logic [KNOB_W-1:0] sample,
                                                 input int unsigned top);
      int unsigned s;
      s = sample;
      if (s >= KNOB_MAX)
         return top;
      return (s * top) / KNOB_MAX;
   endfunction

   // one event applied to the predicted state
   task automatic apply_event(input logic [KIND_W-1:0] kind,
                              input logic [KNOB_W-1:0] mk,
                              input logic [KNOB_W-1:0] sk);
      case (timer_mode)
         CODE_SETTING: begin
            if (kind == KIND_KNOB) begin
               chosen_min = MIN_W'(knob_to_units(mk, MAX_MINUTES));
               chosen_sec = SEC_W'(knob_to_units(sk, MAX_SECONDS));
               left_min   = chosen_min;
               left_sec   = chosen_sec;
            end else if (kind == KIND_FIRE) begin
               timer_mode = CODE_RUNNING;
            end
         end
         CODE_RUNNING: begin
            if (kind == KIND_TICK) begin
               // count down with borrow, no wrap below zero
               if (left_sec != '0) begin
                  left_sec = left_sec - SEC_W'(1);
               end else if (left_min != '0) begin
                  left_min = left_min - MIN_W'(1);
                  left_sec = SECONDS_WRAP;
               end
               if (left_min == '0 && left_sec == '0)
                  timer_mode = CODE_ELAPSED;
            end else if (kind == KIND_FIRE) begin
               timer_mode = CODE_PAUSED;
            end
         end
         CODE_PAUSED: begin
            if (kind == KIND_FIRE) begin
               timer_mode = CODE_RUNNING;
            end else if (kind == KIND_UP) begin
               left_min   = chosen_min;
               left_sec   = chosen_sec;
               timer_mode = CODE_RUNNING;
            end else if (kind == KIND_DOWN) begin
               left_min   = chosen_min;
               left_sec   = chosen_sec;
               timer_mode = CODE_SETTING;
            end
         end
         default: begin
            if (kind == KIND_FIRE) begin
               left_min   = chosen_min;
               left_sec   = chosen_sec;
               timer_mode = CODE_SETTING;
            end
         end
      endcase
   endtask

   // predicted result word from the current state
   function automatic timer_word_type timer_word_now();
      timer_word_type w;
      w.mode           = timer_mode;
      w.minutes_left   = left_min;
      w.seconds_left   = left_sec;
      w.minutes_chosen = chosen_min;
      w.seconds_chosen = chosen_sec;
      case (timer_mode)
         CODE_SETTING: w.lamp_colour = LAMP_RED;
         CODE_RUNNING: w.lamp_colour = LAMP_GREEN;
         CODE_PAUSED:  w.lamp_colour = LAMP_ORANGE;
         default:      w.lamp_colour = LAMP_BLUE;
      endcase
      w.beep_on = (timer_mode == CODE_ELAPSED);
      return w;
   endfunction

   // watch both channels; results are checked before new words are predicted
   always @(posedge clock) begin
      timer_word_type want;
      timer_word_type got;
      if (reset) begin
         timer_mode = CODE_SETTING;
         left_min   = '0;
         left_sec   = '0;
         chosen_min = '0;
         chosen_sec = '0;
         timer_words_due.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.mode           = rsp_mode;
            got.minutes_left   = rsp_minutes_left;
            got.seconds_left   = rsp_seconds_left;
            got.minutes_chosen = rsp_minutes_chosen;
            got.seconds_chosen = rsp_seconds_chosen;
            got.lamp_colour    = rsp_lamp_colour;
            got.beep_on        = rsp_beep_on;
            if (timer_words_due.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("%0t unexpected result word mode %0d left %0d:%0d",
                           $realtime, got.mode, got.minutes_left, got.seconds_left);
            end else begin
               want = timer_words_due.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("%0t result word mismatch (expected/actual):", $realtime);
                     $display("  mode %0d/%0d left %0d:%0d/%0d:%0d",
                              want.mode, got.mode,
                              want.minutes_left, want.seconds_left,
                              got.minutes_left, got.seconds_left);
                     $display("  chosen %0d:%0d/%0d:%0d lamp %0d/%0d beep %0d/%0d",
                              want.minutes_chosen, want.seconds_chosen,
                              got.minutes_chosen, got.seconds_chosen,
                              want.lamp_colour, got.lamp_colour,
                              want.beep_on, got.beep_on);
                  end
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            apply_event(req_kind, req_minutes_knob, req_seconds_knob);
            timer_words_due.push_back(timer_word_now());
         end
      end
      words_pending <= timer_words_due.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for the minute/second countdown controller
// drives event words with bursts, gaps and receiver stalls, and gives the verdict
// depends on mscc_pkg, minute_second_countdown_controller_top and mscc_checker
module tb_top
   import mscc_pkg::*;
();

   localparam int unsigned WORD_TARGET = 1420;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD   = 300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind = KIND_TICK;
   logic [KNOB_W-1:0] req_minutes_knob = '0;
   logic [KNOB_W-1:0] req_seconds_knob = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_mode;
   logic [MIN_W-1:0]  rsp_minutes_left;
   logic [SEC_W-1:0]  rsp_seconds_left;
   logic [MIN_W-1:0]  rsp_minutes_chosen;
   logic [SEC_W-1:0]  rsp_seconds_chosen;
   logic [1:0]        rsp_lamp_colour;
   logic              rsp_beep_on;

   int                fail_count;
   int                words_pending;
   int unsigned       words_sent = 0;
   int unsigned       burst_left = 0;
   int unsigned       cycle_count = 0;
   bit                long_hold_req = 1'b0;

   minute_second_countdown_controller_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_minutes_knob   (req_minutes_knob),
      .req_seconds_knob   (req_seconds_knob),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mode           (rsp_mode),
      .rsp_minutes_left   (rsp_minutes_left),
      .rsp_seconds_left   (rsp_seconds_left),
      .rsp_minutes_chosen (rsp_minutes_chosen),
      .rsp_seconds_chosen (rsp_seconds_chosen),
      .rsp_lamp_colour    (rsp_lamp_colour),
      .rsp_beep_on        (rsp_beep_on)
   );

   mscc_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_minutes_knob   (req_minutes_knob),
      .req_seconds_knob   (req_seconds_knob),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mode           (rsp_mode),
      .rsp_minutes_left   (rsp_minutes_left),
      .rsp_seconds_left   (rsp_seconds_left),
      .rsp_minutes_chosen (rsp_minutes_chosen),
      .rsp_seconds_chosen (rsp_seconds_chosen),
      .rsp_lamp_colour    (rsp_lamp_colour),
      .rsp_beep_on        (rsp_beep_on),
      .fail_count         (fail_count),
      .words_pending      (words_pending)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[minute_second_countdown_controller_top] ERROR");
      $finish;
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int unsigned hold_left;
      int unsigned style;
      int unsigned style_left;
      hold_left  = 0;
      style      = 0;
      style_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (style_left == 0) begin
               style      = $urandom_range(0, 3);
               style_left = $urandom_range(5, 60);
            end
            style_left--;
            case (style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= $urandom_range(0, 1);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   function automatic logic [KNOB_W-1:0] any_knob();
      return KNOB_W'($urandom_range(0, 4095));
   endfunction

   // offer one event word and hold it until accepted
   task automatic send_word(input logic [KIND_W-1:0] kind,
                            input logic [KNOB_W-1:0] mk,
                            input logic [KNOB_W-1:0] sk);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_minutes_knob <= mk;
      req_seconds_knob <= sk;
      do @(posedge clock); while (req_stall !== 1'b0);
      words_sent++;
   endtask

   // stop offering and wait for every result word
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (words_pending != 0) @(posedge clock);
   endtask

   // one well-formed countdown: set, start, tick with pauses, then quit
   task automatic run_countdown();
      logic [KNOB_W-1:0] mk;
      int unsigned       ticks;
      int unsigned       pick;
      case ($urandom_range(0, 19))
         0, 1, 2:       mk = KNOB_W'($urandom_range(410, 818));
         3:             mk = any_knob();
         default:       mk = KNOB_W'($urandom_range(0, 409));
      endcase
      send_word(KIND_KNOB, mk, any_knob());
      if ($urandom_range(0, 3) == 0)
         send_word(KIND_KNOB, KNOB_W'($urandom_range(0, 409)), any_knob());
      send_word(KIND_FIRE, any_knob(), any_knob());
      ticks = $urandom_range(0, (mk < 410) ? 64 : 75);
      for (int unsigned i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            // pause, maybe an ignored word, then resume, reload or quit
            send_word(KIND_FIRE, any_knob(), any_knob());
            if ($urandom_range(0, 1) == 0)
               send_word($urandom_range(0, 1) ? KIND_TICK : KIND_KNOB,
                         any_knob(), any_knob());
            pick = $urandom_range(0, 2);
            if (pick == 0)
               send_word(KIND_FIRE, any_knob(), any_knob());
            else if (pick == 1)
               send_word(KIND_UP, any_knob(), any_knob());
            else begin
               send_word(KIND_DOWN, any_knob(), any_knob());
               return;
            end
         end
         send_word(KIND_TICK, any_knob(), any_knob());
      end
      // from running this pauses then quits; from elapsed the fire quits
      send_word(KIND_FIRE, any_knob(), any_knob());
      send_word(KIND_DOWN, any_knob(), any_knob());
   endtask

   // stimulus and verdict
   initial begin
      bit hold_done;
      bit pause_done;
      int unsigned noise_len;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: unused kinds and stray events in setting
      send_word(KIND_W'(5), 12'hFFF, 12'hFFF);
      send_word(KIND_W'(6), 12'h000, 12'hFFF);
      send_word(KIND_W'(7), 12'hFFF, 12'h000);
      send_word(KIND_TICK, 12'hFFF, 12'hFFF);
      send_word(KIND_UP, 12'h000, 12'h000);
      send_word(KIND_DOWN, 12'h000, 12'h000);
      // start at zero time, first tick elapses, events ignored in elapsed
      send_word(KIND_KNOB, 12'h000, 12'h000);
      send_word(KIND_FIRE, 12'h000, 12'h000);
      send_word(KIND_TICK, 12'h000, 12'h000);
      send_word(KIND_TICK, 12'h000, 12'h000);
      send_word(KIND_KNOB, 12'hFFF, 12'hFFF);
      send_word(KIND_UP, 12'h000, 12'h000);
      send_word(KIND_FIRE, 12'h000, 12'h000);
      // full-scale knob and just below it
      send_word(KIND_KNOB, 12'hFFF, 12'hFFF);
      send_word(KIND_KNOB, 12'hFFE, 12'hFFE);
      // one minute one second: borrow, pause, reload, resume, quit
      send_word(KIND_KNOB, 12'd410, 12'd70);
      send_word(KIND_FIRE, 12'h000, 12'h000);
      send_word(KIND_TICK, 12'h000, 12'h000);
      send_word(KIND_TICK, 12'h000, 12'h000);
      send_word(KIND_FIRE, 12'h000, 12'h000);
      send_word(KIND_TICK, 12'h000, 12'h000);
      send_word(KIND_KNOB, 12'hFFF, 12'hFFF);
      send_word(KIND_UP, 12'h000, 12'h000);
      send_word(KIND_FIRE, 12'h000, 12'h000);
      send_word(KIND_FIRE, 12'h000, 12'h000);
      send_word(KIND_FIRE, 12'h000, 12'h000);
      send_word(KIND_DOWN, 12'h000, 12'h000);
      drain_results();

      // random: mostly countdowns, some noise
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 9) < 7) begin
            run_countdown();
         end else begin
            noise_len = $urandom_range(1, 6);
            repeat (noise_len)
               send_word(KIND_W'($urandom_range(0, 7)), any_knob(), any_knob());
         end
         if (!hold_done && words_sent > 500) begin
            hold_done     = 1'b1;
            long_hold_req = 1'b1;
         end
         if (!pause_done && words_sent > 1000) begin
            pause_done = 1'b1;
            drain_results();
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("[minute_second_countdown_controller_top] OK");
      else
         $display("[minute_second_countdown_controller_top] ERROR");
      $finish;
   end

endmodule
